// ===== hw/rtl/qalu_pkg.sv =====
// Shared types and constants for the Q24.8 fixed-point ALU.
// Transaction structs, action and error codes, pipeline stage structs.
// No dependencies.
package qalu_pkg;

  localparam int unsigned FRAC_BITS_DEF = 8;
  localparam int unsigned FRAC_BITS_MAX = 16;
  localparam int unsigned DVD_W_MAX     = 32 + FRAC_BITS_MAX;

  localparam logic [31:0] RAW_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] RAW_MIN = 32'h8000_0000;

  typedef enum logic [4:0] {
    ACT_ADD       = 5'd0,
    ACT_SUB       = 5'd1,
    ACT_MUL       = 5'd2,
    ACT_DIV       = 5'd3,
    ACT_GT        = 5'd4,
    ACT_LT        = 5'd5,
    ACT_GE        = 5'd6,
    ACT_LE        = 5'd7,
    ACT_EQ        = 5'd8,
    ACT_NE        = 5'd9,
    ACT_MIN       = 5'd10,
    ACT_MAX       = 5'd11,
    ACT_INC       = 5'd12,
    ACT_DEC       = 5'd13,
    ACT_TOINT     = 5'd14,
    ACT_FROMINT   = 5'd15,
    ACT_FROMFLOAT = 5'd16,
    ACT_TOFLOAT   = 5'd17
  } act_t;

  typedef enum logic [1:0] {
    ERR_OK      = 2'd0,
    ERR_DIVZERO = 2'd1,
    ERR_FLOAT   = 2'd2
  } err_t;

  typedef struct packed {
    logic [4:0]         action;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
    logic [31:0]        float_bits;
  } in_t;

  typedef struct packed {
    logic signed [31:0] result;
    logic [31:0]        float_out;
    logic               compare_flag;
    logic [1:0]         error_code;
  } out_t;

  // Front stage output: simple results done, product, float-normalise and divide inputs pending
  typedef struct packed {
    act_t                   act;
    logic [31:0]            res;
    logic                   flag;
    err_t                   err;
    logic signed [63:0]     prod;
    logic                   tf_sign;
    logic                   tf_zero;
    logic [4:0]             tf_p;
    logic [31:0]            tf_mag;
    logic                   dneg;
    logic [31:0]            den;
    logic [DVD_W_MAX-1:0]   dvd;
  } s0_t;

  // Word handed along the divider chain
  typedef struct packed {
    act_t                   act;
    logic [31:0]            res;
    logic [31:0]            fout;
    logic                   flag;
    err_t                   err;
    logic                   dneg;
    logic [31:0]            den;
    logic [31:0]            rem;
    logic [DVD_W_MAX-1:0]   dvd;
  } cell_t;

endpackage

// ===== hw/rtl/fixed_point_q24_8_alu_unit.sv =====
// Top level of the Q24.8 fixed-point ALU: front stage, normalise stage,
// divider chain and output register. Depends on qalu_pkg and all qalu_ modules.
//
// Usage: present a transaction on in_data with in_valid high; it is taken at a
// rising edge where in_stall is low. Each transaction gives exactly one result
// on out_data, qualified by out_valid, taken at an edge where out_stall is low.
// Results leave in the order transactions arrived.
// Pipeline: the front stage takes the transaction at the accepting edge, then
// one normalise stage, one divider cell per quotient bit (32 + FRACTION_BITS
// cells) and the output register, which raises out_valid. Every action
// travels the full chain, so order is kept without reordering logic.
// Throughput: one transaction per cycle while the pipeline is not frozen by a
// stall; each divider cell handles one bit of a different division.
// Stall: while out_valid is high and out_stall is high the whole pipeline
// freezes and in_stall is raised; in_stall does not depend on in_valid.
// Reset: rst_n low at a clock edge clears every stage valid bit; transactions
// in flight are dropped.
module fixed_point_q24_8_alu_unit #(
  parameter int unsigned FRACTION_BITS = qalu_pkg::FRAC_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  qalu_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output qalu_pkg::out_t out_data
);
  import qalu_pkg::*;

  localparam int unsigned DW = 32 + FRACTION_BITS;

  logic        adv;
  logic        v0_r;
  logic [DW:0] cv_r;
  logic        out_valid_r;
  out_t        out_data_r;
  out_t        fin;
  s0_t         s0;
  cell_t       chain [0:DW];
  logic [31:0] quo;

  // Advance everything when the output register is free or being taken
  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  qalu_prep #(.FRACTION_BITS(FRACTION_BITS)) u_prep (
    .clk  (clk),
    .en   (adv),
    .in_i (in_data),
    .s0_o (s0)
  );

  qalu_norm #(.FRACTION_BITS(FRACTION_BITS)) u_norm (
    .clk    (clk),
    .en     (adv),
    .s0_i   (s0),
    .cell_o (chain[0])
  );

  for (genvar g = 0; g < DW; g++) begin : g_cell
    qalu_div_cell #(.FRACTION_BITS(FRACTION_BITS)) u_cell (
      .clk    (clk),
      .en     (adv),
      .cell_i (chain[g]),
      .cell_o (chain[g+1])
    );
  end

  // Apply the quotient sign and pack the result
  always_comb begin
    quo              = chain[DW].dvd[31:0];
    fin.result       = chain[DW].res;
    fin.float_out    = chain[DW].fout;
    fin.compare_flag = chain[DW].flag;
    fin.error_code   = chain[DW].err;
    if ((chain[DW].act == ACT_DIV) && (chain[DW].err == ERR_OK)) begin
      fin.result = chain[DW].dneg ? (32'd0 - quo) : quo;
    end
  end

  // Advance valid bits alongside the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r        <= 1'b0;
      cv_r        <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v0_r        <= in_valid;
      cv_r        <= {cv_r[DW-1:0], v0_r};
      out_valid_r <= cv_r[DW];
    end
  end

  // Hold the result while stalled
  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= fin;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTH
  a_stall_rule: assert property (@(posedge clk)
    in_stall == (out_valid_r && out_stall))
    else $error("in_stall does not follow the output register");

  a_divzero_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.error_code == ERR_DIVZERO)) |->
      ((out_data.result == RAW_MAX) || (out_data.result == RAW_MIN)))
    else $error("divide by zero result not saturated");

  a_flag_excl: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.compare_flag) |->
      ((out_data.result == 32'sd0) && (out_data.float_out == 32'd0)
       && (out_data.error_code == ERR_OK)))
    else $error("compare flag with other result fields set");

  a_float_excl: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.float_out != 32'd0)) |->
      ((out_data.result == 32'sd0) && (out_data.error_code == ERR_OK)))
    else $error("float result with other result fields set");

  a_out_from_chain: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && !cv_r[DW]) |=> !out_valid_r)
    else $error("output valid without a transaction from the chain");
`endif

endmodule

// ===== hw/rtl/qalu_prep.sv =====
// Front stage of the ALU: decodes a transaction, computes the one-step results.
// Also starts multiply, to-float leading-one search and divide setup.
// Depends on qalu_pkg.
module qalu_prep #(
  parameter int unsigned FRACTION_BITS = qalu_pkg::FRAC_BITS_DEF
) (
  input  logic          clk,
  input  logic          en,
  input  qalu_pkg::in_t in_i,
  output qalu_pkg::s0_t s0_o
);
  import qalu_pkg::*;

  s0_t s0_nxt;
  s0_t s0_r;

  logic        ff_sign;
  logic [7:0]  ff_exp;
  logic [23:0] ff_sig;
  logic [7:0]  ff_eu;
  logic signed [9:0] ff_sh;
  logic [9:0]  ff_nm1;
  logic [24:0] ff_t;
  logic [63:0] ff_mag;
  logic [31:0] ff_res;
  err_t        ff_err;
  logic [31:0] abs_a;
  logic [31:0] abs_b;
  logic [31:0] tf_mag;
  logic [4:0]  tf_p;

  // Convert a single-precision pattern to raw fixed, half away from zero
  always_comb begin
    ff_sign = in_i.float_bits[31];
    ff_exp  = in_i.float_bits[30:23];
    ff_sig  = {(ff_exp != 8'd0), in_i.float_bits[22:0]};
    ff_eu   = (ff_exp == 8'd0) ? 8'd1 : ff_exp;
    ff_sh   = $signed({2'b00, ff_eu}) - 10'sd150 + $signed(10'(FRACTION_BITS));
    ff_nm1  = 10'(-ff_sh) - 10'd1;
    ff_t    = 25'd0;
    ff_mag  = 64'd0;
    ff_res  = 32'd0;
    ff_err  = ERR_OK;
    if (ff_exp == 8'hFF) begin
      ff_err = ERR_FLOAT;
      ff_res = ff_sign ? RAW_MIN : RAW_MAX;
    end else if (ff_sig != 24'd0) begin
      if (ff_sh >= 10'sd0) begin
        if (ff_sh > 10'sd31) begin
          ff_err = ERR_FLOAT;
        end else begin
          ff_mag = {40'd0, ff_sig} << ff_sh[4:0];
        end
      end else begin
        if (ff_nm1 < 10'd24) begin
          ff_t = {1'b0, ff_sig >> ff_nm1[4:0]};
        end
        ff_t   = (ff_t + 25'd1) >> 1;
        ff_mag = {39'd0, ff_t};
      end
      if (ff_err == ERR_FLOAT) begin
        ff_res = ff_sign ? RAW_MIN : RAW_MAX;
      end else if (ff_sign) begin
        if (ff_mag > 64'h8000_0000) begin
          ff_err = ERR_FLOAT;
          ff_res = RAW_MIN;
        end else begin
          ff_res = 32'd0 - ff_mag[31:0];
        end
      end else begin
        if (ff_mag > 64'h7FFF_FFFF) begin
          ff_err = ERR_FLOAT;
          ff_res = RAW_MAX;
        end else begin
          ff_res = ff_mag[31:0];
        end
      end
    end
  end

  // Magnitudes and leading-one position
  always_comb begin
    abs_a  = in_i.operand_a[31] ? (~in_i.operand_a + 32'd1) : in_i.operand_a;
    abs_b  = in_i.operand_b[31] ? (~in_i.operand_b + 32'd1) : in_i.operand_b;
    tf_mag = abs_a;
    tf_p   = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (tf_mag[i]) tf_p = 5'(i);
    end
  end

  // Decode the action
  always_comb begin
    s0_nxt         = '0;
    s0_nxt.act     = act_t'(in_i.action);
    s0_nxt.err     = ERR_OK;
    s0_nxt.prod    = in_i.operand_a * in_i.operand_b;
    s0_nxt.tf_sign = in_i.operand_a[31];
    s0_nxt.tf_zero = (in_i.operand_a == 32'sd0);
    s0_nxt.tf_p    = tf_p;
    s0_nxt.tf_mag  = tf_mag;
    s0_nxt.dneg    = in_i.operand_a[31] ^ in_i.operand_b[31];
    s0_nxt.den     = abs_b;
    s0_nxt.dvd     = DVD_W_MAX'(abs_a) << FRACTION_BITS;
    case (act_t'(in_i.action))
      ACT_ADD:       s0_nxt.res = in_i.operand_a + in_i.operand_b;
      ACT_SUB:       s0_nxt.res = in_i.operand_a - in_i.operand_b;
      ACT_DIV: begin
        if (in_i.operand_b == 32'sd0) begin
          s0_nxt.err = ERR_DIVZERO;
          s0_nxt.res = in_i.operand_a[31] ? RAW_MIN : RAW_MAX;
        end
      end
      ACT_GT:        s0_nxt.flag = (in_i.operand_a >  in_i.operand_b);
      ACT_LT:        s0_nxt.flag = (in_i.operand_a <  in_i.operand_b);
      ACT_GE:        s0_nxt.flag = (in_i.operand_a >= in_i.operand_b);
      ACT_LE:        s0_nxt.flag = (in_i.operand_a <= in_i.operand_b);
      ACT_EQ:        s0_nxt.flag = (in_i.operand_a == in_i.operand_b);
      ACT_NE:        s0_nxt.flag = (in_i.operand_a != in_i.operand_b);
      ACT_MIN: s0_nxt.res = (in_i.operand_a > in_i.operand_b) ? in_i.operand_b : in_i.operand_a;
      ACT_MAX: s0_nxt.res = (in_i.operand_a > in_i.operand_b) ? in_i.operand_a : in_i.operand_b;
      ACT_INC:       s0_nxt.res = in_i.operand_a + 32'sd1;
      ACT_DEC:       s0_nxt.res = in_i.operand_a - 32'sd1;
      ACT_TOINT:     s0_nxt.res = in_i.operand_a >>> FRACTION_BITS;
      ACT_FROMINT:   s0_nxt.res = in_i.operand_a << FRACTION_BITS;
      ACT_FROMFLOAT: begin
        s0_nxt.res = ff_res;
        s0_nxt.err = ff_err;
      end
      default: ;
    endcase
  end

  // Hold while the pipeline is stalled
  always_ff @(posedge clk) begin
    if (en) begin
      s0_r <= s0_nxt;
    end
  end

  assign s0_o = s0_r;

endmodule

// ===== hw/rtl/qalu_norm.sv =====
// Second stage: scales the product and rounds the to-float result.
// Emits the word that enters the divider chain. Depends on qalu_pkg.
module qalu_norm #(
  parameter int unsigned FRACTION_BITS = qalu_pkg::FRAC_BITS_DEF
) (
  input  logic            clk,
  input  logic            en,
  input  qalu_pkg::s0_t   s0_i,
  output qalu_pkg::cell_t cell_o
);
  import qalu_pkg::*;

  cell_t       cell_nxt;
  cell_t       cell_r;
  logic [31:0] norm;
  logic        rnd;
  logic [24:0] sum;
  logic [7:0]  fexp;

  // Normalise to bit 31 and round to 24 bits, ties to even
  always_comb begin
    norm = s0_i.tf_mag << (5'd31 - s0_i.tf_p);
    rnd  = norm[7] && ((norm[6:0] != 7'd0) || norm[8]);
    sum  = {1'b0, norm[31:8]} + {24'd0, rnd};
    fexp = 8'(s0_i.tf_p) + 8'd127 - 8'(FRACTION_BITS) + {7'd0, sum[24]};
  end

  // Assemble the chain word
  always_comb begin
    cell_nxt      = '0;
    cell_nxt.act  = s0_i.act;
    cell_nxt.res  = s0_i.res;
    cell_nxt.flag = s0_i.flag;
    cell_nxt.err  = s0_i.err;
    cell_nxt.dneg = s0_i.dneg;
    cell_nxt.den  = s0_i.den;
    cell_nxt.rem  = 32'd0;
    cell_nxt.dvd  = s0_i.dvd;
    if (s0_i.act == ACT_MUL) begin
      cell_nxt.res = s0_i.prod[FRACTION_BITS+31:FRACTION_BITS];
    end
    if ((s0_i.act == ACT_TOFLOAT) && !s0_i.tf_zero) begin
      cell_nxt.fout = {s0_i.tf_sign, fexp, sum[22:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cell_r <= cell_nxt;
    end
  end

  assign cell_o = cell_r;

endmodule

// ===== hw/rtl/qalu_div_cell.sv =====
// One cell of the divider chain: a restoring step yielding one quotient bit.
// Other fields ride along unchanged. Depends on qalu_pkg.
module qalu_div_cell #(
  parameter int unsigned FRACTION_BITS = qalu_pkg::FRAC_BITS_DEF
) (
  input  logic            clk,
  input  logic            en,
  input  qalu_pkg::cell_t cell_i,
  output qalu_pkg::cell_t cell_o
);
  import qalu_pkg::*;

  localparam int unsigned DW = 32 + FRACTION_BITS;

  cell_t       cell_nxt;
  cell_t       cell_r;
  logic [32:0] trial;
  logic        qbit;

  // Shift in the next dividend bit, subtract the divisor where it fits
  always_comb begin
    trial    = {cell_i.rem, cell_i.dvd[DW-1]};
    qbit     = (trial >= {1'b0, cell_i.den});
    cell_nxt = cell_i;
    cell_nxt.rem = qbit ? 32'(trial - {1'b0, cell_i.den}) : trial[31:0];
    cell_nxt.dvd = {cell_i.dvd[DVD_W_MAX-2:0], qbit};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cell_r <= cell_nxt;
    end
  end

  assign cell_o = cell_r;

endmodule
